FILE: rtl/core/cqs_pkg.sv
// Package for the circular queue with search.
// Holds the operation codes, used by the core, and the result status codes shared by the core and its checker.
// No dependencies.
package cqs_pkg;

    localparam int unsigned KindW   = 3;
    localparam int unsigned StatusW = 2;
    localparam int unsigned ValueW  = 32;

    typedef enum logic [KindW-1:0] {
        KIND_ENQUEUE = 3'd0,
        KIND_DEQUEUE = 3'd1,
        KIND_UPDATE  = 3'd2,
        KIND_SEARCH  = 3'd3,
        KIND_COUNT   = 3'd4
    } t_kind;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

endpackage

FILE: rtl/core/circular_queue_with_search.sv
// Ring-buffer queue of signed 32-bit values with enqueue, dequeue, update, search and count.
// Depends on cqs_pkg; the slot storage is a one-port-read, one-port-write synchronous memory.
//
//  Channel   Dir  Handshake              Payload
//  s_axis    in   tvalid/tready          tdata: item_value, replacement; tuser: kind
//  m_axis    out  tvalid/tready          tdata: status, head_value, occupancy
//
// Enqueue, count and refused requests go straight to the result step; dequeue passes through
// a read step, and update and search through a scan. The scan reads one slot per cycle
// through the memory's single read port, visiting entries in order from the head. Reset
// (synchronous, active low) empties the queue at once; slot contents are not cleared. A
// result waits in the output register while the next request is taken; a finished request
// holds in its last step until that register frees up.
module circular_queue_with_search
    import cqs_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [31:0] item_value, [63:32] replacement
    input  logic [2*ValueW-1:0]      s_axis_tdata,
    // [2:0] kind
    input  logic [KindW-1:0]         s_axis_tuser,

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [1:0] status, [33:2] head_value, then occupancy, zero fill to whole bytes
    output logic [((StatusW+ValueW+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned OW   = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
    localparam logic [OW-1:0] FullLvl = OW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [OW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [OW-1:0] r_cnt, n_cnt;
    t_kind r_kind, n_kind;
    logic signed [ValueW-1:0] r_val, n_val;
    logic signed [ValueW-1:0] r_rep, n_rep;
    t_status r_status, n_status;
    logic signed [ValueW-1:0] r_head_val, n_head_val;

    logic r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    logic signed [ValueW-1:0] r_out_head, n_out_head;
    logic [OW-1:0] r_out_occ, n_out_occ;

    // Slot storage.
    logic [ValueW-1:0] mem [DEPTH];
    logic [ValueW-1:0] r_rd_data;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [ValueW-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic in_take;
    logic out_free;

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
        return (p == LastIdx) ? '0 : AW'(p + 1'b1);
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_fill       = r_fill;
        n_ptr        = r_ptr;
        n_cnt        = r_cnt;
        n_kind       = r_kind;
        n_val        = r_val;
        n_rep        = r_rep;
        n_status     = r_status;
        n_head_val   = r_head_val;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_head   = r_out_head;
        n_out_occ    = r_out_occ;
        mem_we       = 1'b0;
        mem_waddr    = r_tail;
        mem_wdata    = r_val;
        mem_re       = 1'b0;
        mem_raddr    = r_head;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_kind     = t_kind'(s_axis_tuser);
                    n_val      = s_axis_tdata[ValueW-1:0];
                    n_rep      = s_axis_tdata[2*ValueW-1:ValueW];
                    n_status   = ST_OK;
                    n_head_val = '0;
                    n_ptr      = r_head;
                    n_cnt      = '0;
                    n_state    = S_DONE;
                    case (t_kind'(s_axis_tuser))
                        KIND_ENQUEUE: begin
                            if (r_fill == FullLvl) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_tail;
                                mem_wdata = s_axis_tdata[ValueW-1:0];
                                n_tail    = wrap_next(r_tail);
                                n_fill    = OW'(r_fill + 1'b1);
                            end
                        end
                        KIND_DEQUEUE: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_head;
                                n_state   = S_DEQ;
                            end
                        end
                        KIND_UPDATE, KIND_SEARCH: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_head;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DEQ: begin
                n_head_val = r_rd_data;
                n_head     = wrap_next(r_head);
                n_fill     = OW'(r_fill - 1'b1);
                n_state    = S_DONE;
            end
            S_SCAN: begin
                // r_rd_data holds the slot at r_ptr; the next slot is fetched meanwhile unless the scan ends.
                if (r_rd_data == r_val) begin
                    if (r_kind == KIND_UPDATE) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_ptr;
                        mem_wdata = r_rep;
                    end
                    n_state = S_DONE;
                end else if (OW'(r_cnt + 1'b1) == r_fill) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = wrap_next(r_ptr);
                    n_ptr     = wrap_next(r_ptr);
                    n_cnt     = OW'(r_cnt + 1'b1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_head   = r_head_val;
                    n_out_occ    = r_fill;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_ptr        <= n_ptr;
        r_cnt        <= n_cnt;
        r_kind       <= n_kind;
        r_val        <= n_val;
        r_rep        <= n_rep;
        r_status     <= n_status;
        r_head_val   <= n_head_val;
        r_out_status <= n_out_status;
        r_out_head   <= n_out_head;
        r_out_occ    <= n_out_occ;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[StatusW-1:0]                = r_out_status;
        m_axis_tdata[StatusW +: ValueW]          = r_out_head;
        m_axis_tdata[StatusW + ValueW +: OW]     = r_out_occ;
    end

endmodule

FILE: rtl/core/cqs_checker.sv
// Port-level checker for the circular queue with search, bound to the top level.
// Depends on cqs_pkg; watches only the result channel.
module cqs_checker
    import cqs_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((StatusW+ValueW+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned OW = $clog2(DEPTH + 1);

    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  head_value;
    logic [OW-1:0]      occupancy;

    assign status     = m_axis_tdata[StatusW-1:0];
    assign head_value = m_axis_tdata[StatusW +: ValueW];
    assign occupancy  = m_axis_tdata[StatusW + ValueW +: OW];

    // A stalled result must hold.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> occupancy <= OW'(DEPTH))
        else $error("occupancy above depth");

    // A refused enqueue only happens on a full queue and returns no value.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_FULL |-> occupancy == OW'(DEPTH) && head_value == '0)
        else $error("full status with wrong occupancy or value");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_EMPTY |-> occupancy == '0 && head_value == '0)
        else $error("empty status with entries or value");

    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_NOT_FOUND |-> occupancy != '0 && head_value == '0)
        else $error("not-found status on an empty queue or with value");

endmodule

bind circular_queue_with_search cqs_checker #(.DEPTH(DEPTH)) u_cqs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
